>>> rtl/tqle_pkg.sv
// Types, constants and index helpers shared by the Q-learning engine.
`default_nettype none
package tqle_pkg;

  localparam int STATE_COUNT  = 4;
  localparam int ACTION_COUNT = 3;
  localparam int TABLE_SIZE   = STATE_COUNT * ACTION_COUNT;

  localparam int CMD_W   = 2;
  localparam int IDX_W   = 2;
  localparam int Q_W     = 24;
  localparam int FRAC_W  = 16;
  localparam int COEF_W  = FRAC_W + 1;
  localparam int ACC_W   = Q_W + 2;
  localparam int NV_W    = Q_W + 3;
  localparam int MUL_W   = COEF_W + ACC_W;
  localparam int REG_W   = 2;

  localparam int SW      = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
  localparam int AW      = (ACTION_COUNT > 1) ? $clog2(ACTION_COUNT) : 1;
  localparam int CW      = $clog2(ACTION_COUNT + 1);
  localparam int ADDR_W  = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

  localparam logic [CMD_W-1:0] CMD_CHOOSE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd3;

  localparam logic [REG_W-1:0] REG_LEARN_RATE   = 2'd0;
  localparam logic [REG_W-1:0] REG_DISCOUNT     = 2'd1;
  localparam logic [REG_W-1:0] REG_EXPLORE_RATE = 2'd2;

  localparam logic [FRAC_W-1:0] RST_LEARN_RATE   = 16'd6554;
  localparam logic [FRAC_W-1:0] RST_DISCOUNT     = 16'd58982;
  localparam logic [FRAC_W-1:0] RST_EXPLORE_RATE = 16'd6554;

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [IDX_W-1:0]        cur_state;
    logic [IDX_W-1:0]        act;
    logic [IDX_W-1:0]        next_state;
    logic signed [Q_W-1:0]   reward;
    logic signed [Q_W-1:0]   entry_value;
    logic [FRAC_W-1:0]       rand_explore;
    logic [FRAC_W-1:0]       rand_pick;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]        chosen_action;
    logic                    explored;
    logic signed [Q_W-1:0]   q_value;
    logic                    saturated;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAX,
    ST_TMUL,
    ST_TIE,
    ST_XMUL,
    ST_XPICK,
    ST_GMUL,
    ST_TGT,
    ST_DIFF,
    ST_AMUL,
    ST_NEW,
    ST_RADDR,
    ST_RDATA,
    ST_WRITE,
    ST_DONE
  } st_t;

  function automatic logic [SW-1:0] st_mod(input logic [IDX_W-1:0] v);
    int t;
    t = int'(v);
    if (t >= STATE_COUNT) t = t - STATE_COUNT;
    return SW'(t);
  endfunction

  function automatic logic [AW-1:0] act_mod(input logic [IDX_W-1:0] v);
    int t;
    t = int'(v);
    if (t >= ACTION_COUNT) t = t - ACTION_COUNT;
    return AW'(t);
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [SW-1:0] row,
                                                input logic [AW-1:0] a);
    return ADDR_W'(int'(row) * ACTION_COUNT + int'(a));
  endfunction

endpackage
`default_nettype wire

>>> rtl/tabular_q_learning_engine_unit.sv
// Top level of the tabular Q-learning engine: sequencer, Q table and shared multiplier.
//
// Input words arrive on in_valid/in_ready, one command each (choose, update, read,
// write); every word yields exactly one result word on out_valid/out_ready.
// Configuration (learn_rate, discount, explore_rate) is written through cfg_wr_en/
// cfg_index/cfg_data; the user must do so only while the engine is idle (the block
// does not enforce it); unknown indexes are dropped. One word is processed at a time;
// in_ready is high only while the sequencer idles. Write stores the entry; read
// sets the address, then takes the data; exploring choose scales rand_pick by
// ACTION_COUNT, then picks; greedy choose scans the row for its maximum, scales
// rand_pick by the tie count and scans again for that tie; update scans the next-state
// row, then forms the discount product, target, difference, learn-rate product and new
// value. Scans read the single read port of the Q table one entry a cycle.
// The result register holds a finished word while the receiver stalls; the sequencer
// waits in its final step until that register is free, and in_ready rises again once
// the word is moved there. Every product uses the one 17x26 multiplier in turn.
// Reset clears the sequencer, the valid flag of the result register and a per-entry
// valid bit, so the whole table reads as zero at once; no clearing pass is needed.
// The configuration registers return to 0.1, 0.9 and 0.1 in Q0.16.
`default_nettype none
module tabular_q_learning_engine_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire tqle_pkg::in_t               in_word,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output tqle_pkg::out_t                   out_word,
  input  wire logic                        cfg_wr_en,
  input  wire logic [tqle_pkg::REG_W-1:0]  cfg_index,
  input  wire logic [tqle_pkg::FRAC_W-1:0] cfg_data
);
  import tqle_pkg::*;

  st_t                      state, state_next;
  in_t                      item, item_next;
  out_t                     res, res_next;
  logic [CW-1:0]            idx, idx_next;
  logic [CW-1:0]            cnt, cnt_next;
  logic [CW-1:0]            k_sel, k_sel_next;
  logic                     found, found_next;
  logic signed [Q_W-1:0]    best, best_next;
  logic signed [Q_W-1:0]    cur, cur_next;
  logic signed [ACC_W-1:0]  acc, acc_next;
  logic signed [MUL_W-1:0]  prod, prod_next;
  logic [FRAC_W-1:0]        learn_rate, discount, explore_rate;

  logic signed [Q_W-1:0]    mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0]    valid;
  logic signed [Q_W-1:0]    rd_data;
  logic                     rd_vld;
  logic [ADDR_W-1:0]        rd_addr, wr_addr;
  logic                     wr_en;
  logic signed [Q_W-1:0]    wr_data;

  logic signed [COEF_W-1:0] mul_a;
  logic signed [ACC_W-1:0]  mul_b;
  logic signed [MUL_W-1:0]  mul_p;
  logic signed [MUL_W-1:0]  prod_sh;
  logic signed [NV_W-1:0]   nv;
  logic                     nv_ovf;
  logic signed [Q_W-1:0]    ent;
  logic [SW-1:0]            cur_row, nxt_row, scan_row;
  logic [AW-1:0]            cur_act, scan_a;
  logic [ADDR_W-1:0]        cur_addr, scan_addr;
  logic                     load_out;

  assign in_ready  = (state == ST_IDLE);
  assign cur_row   = st_mod(item.cur_state);
  assign nxt_row   = st_mod(item.next_state);
  assign cur_act   = act_mod(item.act);
  assign scan_row  = (item.cmd == CMD_UPDATE) ? nxt_row : cur_row;
  assign scan_a    = (idx < CW'(ACTION_COUNT)) ? AW'(idx) : '0;
  assign cur_addr  = addr_of(cur_row, cur_act);
  assign scan_addr = addr_of(scan_row, scan_a);
  assign ent       = rd_vld ? rd_data : '0;
  assign mul_p     = mul_a * mul_b;
  assign prod_sh   = prod >>> FRAC_W;
  assign nv        = $signed({{(NV_W-Q_W){cur[Q_W-1]}}, cur}) + $signed(prod_sh[NV_W-1:0]);
  assign nv_ovf    = (nv[NV_W-1:Q_W-1] != '0) && (nv[NV_W-1:Q_W-1] != '1);

  always_comb begin
    state_next = state;
    item_next  = item;
    res_next   = res;
    idx_next   = idx;
    cnt_next   = cnt;
    k_sel_next = k_sel;
    found_next = found;
    best_next  = best;
    cur_next   = cur;
    acc_next   = acc;
    prod_next  = prod;
    rd_addr    = cur_addr;
    wr_addr    = cur_addr;
    wr_en      = 1'b0;
    wr_data    = item.entry_value;
    mul_a      = '0;
    mul_b      = '0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          item_next  = in_word;
          res_next   = '0;
          idx_next   = '0;
          found_next = 1'b0;
          case (in_word.cmd)
            CMD_CHOOSE: begin
              if (in_word.rand_explore < explore_rate) state_next = ST_XMUL;
              else state_next = ST_MAX;
            end
            CMD_UPDATE: state_next = ST_MAX;
            CMD_READ:   state_next = ST_RADDR;
            default:    state_next = ST_WRITE;
          endcase
        end
      end
      ST_MAX: begin
        rd_addr = scan_addr;
        if (idx != '0) begin
          if ((idx == CW'(1)) || (ent > best)) begin
            best_next = ent;
            cnt_next  = CW'(1);
          end else if (ent == best) begin
            cnt_next = cnt + CW'(1);
          end
        end
        if (idx == CW'(ACTION_COUNT)) begin
          idx_next   = '0;
          state_next = (item.cmd == CMD_UPDATE) ? ST_GMUL : ST_TMUL;
        end else begin
          idx_next = idx + CW'(1);
        end
      end
      ST_TMUL: begin
        mul_a      = $signed({1'b0, item.rand_pick});
        mul_b      = $signed({{(ACC_W-CW){1'b0}}, cnt});
        prod_next  = mul_p;
        state_next = ST_TIE;
      end
      ST_TIE: begin
        rd_addr = scan_addr;
        if (idx == '0) begin
          k_sel_next = prod[FRAC_W +: CW];
        end else if ((ent == best) && !found) begin
          if (k_sel == '0) begin
            res_next.chosen_action = IDX_W'(idx - CW'(1));
            found_next             = 1'b1;
          end else begin
            k_sel_next = k_sel - CW'(1);
          end
        end
        if (idx == CW'(ACTION_COUNT)) state_next = ST_DONE;
        else idx_next = idx + CW'(1);
      end
      ST_XMUL: begin
        mul_a      = $signed({1'b0, item.rand_pick});
        mul_b      = ACC_W'(ACTION_COUNT);
        prod_next  = mul_p;
        state_next = ST_XPICK;
      end
      ST_XPICK: begin
        res_next.chosen_action = IDX_W'(prod[FRAC_W +: AW]);
        res_next.explored      = 1'b1;
        state_next             = ST_DONE;
      end
      ST_GMUL: begin
        mul_a      = $signed({1'b0, discount});
        mul_b      = $signed({{(ACC_W-Q_W){best[Q_W-1]}}, best});
        prod_next  = mul_p;
        state_next = ST_TGT;
      end
      ST_TGT: begin
        cur_next   = ent;
        acc_next   = $signed({{(ACC_W-Q_W){item.reward[Q_W-1]}}, item.reward})
                   + $signed(prod_sh[ACC_W-1:0]);
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        acc_next   = acc - $signed({{(ACC_W-Q_W){cur[Q_W-1]}}, cur});
        state_next = ST_AMUL;
      end
      ST_AMUL: begin
        mul_a      = $signed({1'b0, learn_rate});
        mul_b      = acc;
        prod_next  = mul_p;
        state_next = ST_NEW;
      end
      ST_NEW: begin
        wr_en = 1'b1;
        if (nv_ovf) wr_data = nv[NV_W-1] ? Q_MIN : Q_MAX;
        else wr_data = nv[Q_W-1:0];
        res_next.q_value   = wr_data;
        res_next.saturated = nv_ovf;
        state_next         = ST_DONE;
      end
      ST_RADDR: begin
        state_next = ST_RDATA;
      end
      ST_RDATA: begin
        res_next.q_value = ent;
        state_next       = ST_DONE;
      end
      ST_WRITE: begin
        wr_en            = 1'b1;
        res_next.q_value = item.entry_value;
        state_next       = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    item  <= item_next;
    res   <= res_next;
    idx   <= idx_next;
    cnt   <= cnt_next;
    k_sel <= k_sel_next;
    found <= found_next;
    best  <= best_next;
    cur   <= cur_next;
    acc   <= acc_next;
    prod  <= prod_next;
    if (load_out) out_word <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate   <= RST_LEARN_RATE;
      discount     <= RST_DISCOUNT;
      explore_rate <= RST_EXPLORE_RATE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LEARN_RATE:   learn_rate   <= cfg_data;
        REG_DISCOUNT:     discount     <= cfg_data;
        REG_EXPLORE_RATE: explore_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
    rd_vld  <= valid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= '0;
    else if (wr_en) valid[wr_addr] <= 1'b1;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("engine accepted a word while still busy");

  a_sat_clamped: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.saturated) |-> ((out_word.q_value == Q_MAX) ||
                                           (out_word.q_value == Q_MIN)))
    else $error("saturated result not at a range limit");

  a_explore_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.explored) |-> ((out_word.q_value == '0) && !out_word.saturated))
    else $error("exploring choice carries a value or saturation flag");

  a_action_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (int'(out_word.chosen_action) < ACTION_COUNT))
    else $error("chosen action out of range");

endmodule
`default_nettype wire
